### hw/rtl/serial_pattern_loopback_detector_defines.svh
// Assertion macros shared by the loopback detector RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef SERIAL_PATTERN_LOOPBACK_DETECTOR_DEFINES_SVH
`define SERIAL_PATTERN_LOOPBACK_DETECTOR_DEFINES_SVH

// same-cycle implication, off during reset
`define SPLD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SPLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/spld_pkg.sv
// Shared types and codes for the serial pattern loopback detector.
// No dependencies.
package spld_pkg;

    // command codes carried on s_tuser
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // status codes of a result item
    localparam logic [2:0] ST_RUNNING     = 3'd0;
    localparam logic [2:0] ST_MATCHED     = 3'd1;
    localparam logic [2:0] ST_END_ACTIVE  = 3'd2;
    localparam logic [2:0] ST_END_IDLE    = 3'd3;
    localparam logic [2:0] ST_NOT_RUNNING = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_PATTERN_BITS    = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH  = 2'd1;
    localparam logic [1:0] REG_ITERATION_LIMIT = 2'd2;

    // field widths
    localparam int CFG_W      = 64;
    localparam int LEN_W      = 7;
    localparam int LIMIT_W    = 11;
    localparam int REGLEN_W   = 10;
    localparam int TOGGLE_W   = 8;
    localparam int LIMIT_MAX  = 1024;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    // control from the scan sequencer to the window
    typedef struct packed {
        logic clear;
        logic shift;
        logic level;
    } win_ctrl_t;

endpackage

### hw/rtl/spld_window.sv
// Return window of the loopback detector: shift register plus pattern compare.
// Depends on spld_pkg.
module spld_window #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  spld_pkg::win_ctrl_t                    ctrl,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]       len,
    input  logic [MAX_PATTERN-1:0]                 pattern,
    output logic                                   match
);
    import spld_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN-1:0] window_reg;
    logic [MAX_PATTERN-1:0] window_next;
    logic [MAX_PATTERN-1:0] mask;
    logic [MAX_PATTERN-1:0] shifted;

    // bits below the length in use, new level ored in at the top one
    // (a bit left above a shrunk length folds into the top of the window once)
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            mask[i]    = LW'(i) < len;
            shifted[i] = ((i < MAX_PATTERN - 1) ? window_reg[(i + 1) % MAX_PATTERN] : 1'b0)
                       | ((LW'(i) == len - LW'(1)) ? ctrl.level : 1'b0);
        end
    end

    // next window and compare against the masked pattern
    always_comb
    begin
        if (ctrl.clear)
            window_next = '0;
        else if (ctrl.shift)
            window_next = shifted & mask;
        else
            window_next = window_reg;
        match = ((shifted & mask) == (pattern & mask));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else
            window_reg <= window_next;
    end

endmodule

### hw/rtl/serial_pattern_loopback_detector.sv
// Top level of the serial pattern loopback detector: scan sequencer,
// counters, configuration registers and the result register.
// Depends on spld_pkg, spld_window and serial_pattern_loopback_detector_defines.svh.
//
// Each start or sample command updates the scan
// state and the window compare in the cycle it is accepted, and its result
// sits in a single output register that frees up in the same cycle it is taken,
// so one item per clock flows through while m_tready stays high. A start item
// answers with the first bit to drive; each sample item answers with the next
// bit, or with the match length or the end status once the scan stops.
// Configuration writes are taken at any edge with cfg_we high and are meant
// for times when no item is in flight.
module serial_pattern_loopback_detector #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [spld_pkg::CFG_W-1:0]           cfg_data,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [spld_pkg::IN_DATA_W-1:0]       s_tdata,  // [0] line_level
    input  logic                                 s_tuser,  // [0] cmd
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] drive_bit, [3:1] status, [13:4] reg_length, [21:14] toggle_total
    output logic [spld_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import spld_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int PW = $clog2(MAX_PATTERN);

    // configuration registers
    logic [MAX_PATTERN-1:0] pattern_reg;
    logic [LEN_W-1:0]       length_cfg_reg;
    logic [LIMIT_W-1:0]     limit_cfg_reg;

    // scan state
    logic [PW-1:0]          pos_reg,     pos_next;
    logic [LIMIT_W-1:0]     sampled_reg, sampled_next;
    logic                   prev_reg,    prev_next;
    logic [TOGGLE_W-1:0]    toggle_reg,  toggle_next;
    logic                   running_reg, running_next;

    // result register
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic                   accept;
    logic                   cmd;
    logic                   level;
    logic [LEN_W-1:0]       len7;
    logic [LW-1:0]          len_used;
    logic [LIMIT_W-1:0]     limit_used;
    logic [LEN_W-1:0]       pos_inc;
    logic                   win_match;
    win_ctrl_t              win_ctrl;

    logic                   drive;
    logic [2:0]             status;
    logic [REGLEN_W-1:0]    reg_length;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign cmd      = s_tuser;
    assign level    = s_tdata[0];

    // clamp the configured length and limit to their legal ranges
    always_comb
    begin
        if (length_cfg_reg == '0)
            len7 = LEN_W'(1);
        else if (length_cfg_reg > LEN_W'(MAX_PATTERN))
            len7 = LEN_W'(MAX_PATTERN);
        else
            len7 = length_cfg_reg;
        len_used = len7[LW-1:0];

        if (limit_cfg_reg == '0)
            limit_used = LIMIT_W'(1);
        else if (limit_cfg_reg > LIMIT_W'(LIMIT_MAX))
            limit_used = LIMIT_W'(LIMIT_MAX);
        else
            limit_used = limit_cfg_reg;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg    <= '0;
            length_cfg_reg <= LEN_W'(32);
            limit_cfg_reg  <= LIMIT_W'(128);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_BITS:    pattern_reg    <= cfg_data[MAX_PATTERN-1:0];
                REG_PATTERN_LENGTH:  length_cfg_reg <= cfg_data[LEN_W-1:0];
                REG_ITERATION_LIMIT: limit_cfg_reg  <= cfg_data[LIMIT_W-1:0];
                default:             ;
            endcase
        end
    end

    spld_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (win_ctrl),
        .len     (len_used),
        .pattern (pattern_reg),
        .match   (win_match)
    );

    // scan sequencer: next state and the result of the accepted item
    always_comb
    begin
        pos_next     = pos_reg;
        sampled_next = sampled_reg;
        prev_next    = prev_reg;
        toggle_next  = toggle_reg;
        running_next = running_reg;
        win_ctrl     = '{clear: 1'b0, shift: 1'b0, level: level};
        drive        = 1'b0;
        status       = ST_NOT_RUNNING;
        reg_length   = '0;
        pos_inc      = LEN_W'(pos_reg) + LEN_W'(1);

        if (accept)
        begin
            if (cmd == CMD_START)
            begin
                prev_next      = level;
                pos_next       = '0;
                sampled_next   = '0;
                toggle_next    = '0;
                running_next   = 1'b1;
                win_ctrl.clear = 1'b1;
                drive          = pattern_reg[0];
                status         = ST_RUNNING;
            end
            else if (running_reg)
            begin
                pos_next       = (pos_inc >= len7) ? '0 : pos_inc[PW-1:0];
                if (level != prev_reg)
                    toggle_next = toggle_reg + TOGGLE_W'(1);
                prev_next      = level;
                win_ctrl.shift = 1'b1;
                sampled_next   = sampled_reg + LIMIT_W'(1);

                if (sampled_next >= LIMIT_W'(len7) && win_match)
                begin
                    status       = ST_MATCHED;
                    reg_length   = REGLEN_W'(sampled_next - LIMIT_W'(len7));
                    running_next = 1'b0;
                end
                else if (sampled_next >= limit_used)
                begin
                    status       = (toggle_next > TOGGLE_W'(1)) ? ST_END_ACTIVE : ST_END_IDLE;
                    running_next = 1'b0;
                end
                else
                begin
                    status = ST_RUNNING;
                    drive  = pattern_reg[pos_next];
                end
            end
        end

        out_data_next = {2'b00, toggle_next, reg_length, status, drive};
    end

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            sampled_reg <= '0;
            prev_reg    <= 1'b0;
            toggle_reg  <= '0;
            running_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            sampled_reg <= sampled_next;
            prev_reg    <= prev_next;
            toggle_reg  <= toggle_next;
            running_reg <= running_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`include "serial_pattern_loopback_detector_defines.svh"

    `SPLD_ASSERT_IMPL(a_stop_reports_end, $fell(running_reg), m_tvalid && (m_tdata[3:1] == ST_MATCHED || m_tdata[3:1] == ST_END_ACTIVE || m_tdata[3:1] == ST_END_IDLE), "scan stopped without a final status")
    `SPLD_ASSERT_IMPL(a_drive_only_running, m_tvalid && m_tdata[3:1] != ST_RUNNING, m_tdata[0] == 1'b0, "drive bit set outside a running scan")
    `SPLD_ASSERT_IMPL(a_length_only_match, m_tvalid && m_tdata[13:4] != '0, m_tdata[3:1] == ST_MATCHED, "register length without a match")
    `SPLD_ASSERT_NEXT(a_start_runs, accept && cmd == CMD_START, running_reg && sampled_reg == '0, "start did not arm the scan")
    `SPLD_ASSERT_IMPL(a_sample_bound, 1'b1, sampled_reg <= LIMIT_W'(LIMIT_MAX), "sample count ran past the limit")

endmodule

### tb/tb_serial_pattern_loopback_detector.sv
// Self-checking testbench for serial_pattern_loopback_detector: streams start and
// sample items, predicts every result item in step and compares field by field.
// Depends on spld_pkg and the detector RTL.
module tb_serial_pattern_loopback_detector;

    import spld_pkg::*;

    localparam int MAX_PATTERN_BITS = 64;
    localparam int RANDOM_ITEMS     = 1350;
    localparam int STALL_LIMIT      = 1000;

    // one input item
    typedef struct packed {
        logic cmd;
        logic level;
    } line_item_t;

    // one expected result item
    typedef struct packed {
        logic                drive_bit;
        logic [2:0]          status;
        logic [REGLEN_W-1:0] reg_length;
        logic [TOGGLE_W-1:0] toggle_total;
    } scan_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = REG_PATTERN_BITS;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = CMD_START;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    line_item_t   line_items[$];
    scan_report_t predicted_reports[$];
    int unsigned  queued_items = 0;
    int unsigned  mismatches = 0;
    int unsigned  stall_cycles = 0;
    bit           no_idle = 1'b0;

    // register copies as written
    logic [CFG_W-1:0]   cfg_pattern = '0;
    logic [LEN_W-1:0]   cfg_length = 7'd32;
    logic [LIMIT_W-1:0] cfg_limit = 11'd128;

    // scan state of the predictor
    logic [63:0]          window_bits = '0;
    logic [5:0]           drive_pos = '0;
    logic [LIMIT_W-1:0]   sampled_count = '0;
    logic                 last_level = 1'b0;
    logic [TOGGLE_W-1:0]  toggle_count = '0;
    logic                 scanning = 1'b0;

    serial_pattern_loopback_detector #(
        .MAX_PATTERN(MAX_PATTERN_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #10 clk = ~clk;

    // pattern length and limit after clamping
    function automatic int unsigned len_in_use();
        if (cfg_length == 0)
            return 1;
        if (cfg_length > MAX_PATTERN_BITS)
            return MAX_PATTERN_BITS;
        return cfg_length;
    endfunction

    function automatic int unsigned limit_in_use();
        if (cfg_limit == 0)
            return 1;
        if (cfg_limit > LIMIT_MAX)
            return LIMIT_MAX;
        return cfg_limit;
    endfunction

    // advance the scan by one accepted item and queue its result
    task automatic step_scan_model(input logic cmd, input logic level);
        scan_report_t rep;
        int unsigned  len;
        int unsigned  nxt;
        logic [63:0]  mask;
        begin
            rep = '0;
            len = len_in_use();
            mask = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
            if (cmd == CMD_START)
            begin
                last_level = level;
                window_bits = '0;
                drive_pos = '0;
                sampled_count = '0;
                toggle_count = '0;
                scanning = 1'b1;
                rep.drive_bit = cfg_pattern[0];
                rep.status = ST_RUNNING;
            end
            else if (!scanning)
            begin
                rep.status = ST_NOT_RUNNING;
            end
            else
            begin
                // position wraps at the length in use, even after a shrink
                nxt = drive_pos + 1;
                if (nxt >= len)
                    nxt = 0;
                drive_pos = nxt[5:0];
                if (level != last_level)
                    toggle_count = toggle_count + 1'b1;
                last_level = level;
                window_bits = ((window_bits >> 1) | ({63'd0, level} << (len - 1))) & mask;
                sampled_count = sampled_count + 1'b1;
                if (sampled_count >= len && window_bits == (cfg_pattern & mask))
                begin
                    rep.status = ST_MATCHED;
                    rep.reg_length = REGLEN_W'(sampled_count - len);
                    scanning = 1'b0;
                end
                else if (sampled_count >= limit_in_use())
                begin
                    rep.status = (toggle_count > 1) ? ST_END_ACTIVE : ST_END_IDLE;
                    scanning = 1'b0;
                end
                else
                begin
                    rep.status = ST_RUNNING;
                    rep.drive_bit = cfg_pattern[drive_pos];
                end
            end
            rep.toggle_total = toggle_count;
            predicted_reports.push_back(rep);
        end
    endtask

    // input side: hold each item until taken, idle at random
    always @(posedge clk)
    begin : line_driver
        logic taken;
        taken = s_tvalid && s_tready;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (taken)
            begin
                step_scan_model(s_tuser, s_tdata[0]);
                void'(line_items.pop_front());
            end
            if (!s_tvalid || taken)
            begin
                if (line_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= 14))
                begin
                    s_tvalid <= 1'b1;
                    s_tuser <= line_items[0].cmd;
                    s_tdata <= {7'd0, line_items[0].level};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each result item with the oldest prediction
    always @(posedge clk)
    begin : report_monitor
        scan_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_reports.size() == 0)
            begin
                $error("unexpected result item %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                if (m_tdata[0] !== want.drive_bit)
                begin
                    $error("drive_bit: expected %0d, actual %0d", want.drive_bit, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[3:1] !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[3:1]);
                    mismatches++;
                end
                if (m_tdata[13:4] !== want.reg_length)
                begin
                    $error("reg_length: expected %0d, actual %0d", want.reg_length,
                        m_tdata[13:4]);
                    mismatches++;
                end
                if (m_tdata[21:14] !== want.toggle_total)
                begin
                    $error("toggle_total: expected %0d, actual %0d", want.toggle_total,
                        m_tdata[21:14]);
                    mismatches++;
                end
            end
        end
        m_tready <= no_idle || $urandom_range(0, 99) >= 14;
    end

    // watchdog on cycles with work outstanding and no handshake
    always @(posedge clk)
    begin
        if (rst_n && (line_items.size() != 0 || predicted_reports.size() != 0)
            && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
            stall_cycles <= stall_cycles + 1;
        else
            stall_cycles <= 0;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_item(input logic cmd, input logic level);
        line_item_t it;
        begin
            it.cmd = cmd;
            it.level = level;
            line_items.push_back(it);
            queued_items++;
        end
    endtask

    // register write while idle, mirrored into the predictor copy
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value;
            case (idx)
                REG_PATTERN_BITS:    cfg_pattern = value;
                REG_PATTERN_LENGTH:  cfg_length = value[LEN_W-1:0];
                REG_ITERATION_LIMIT: cfg_limit = value[LIMIT_W-1:0];
                default:             ;
            endcase
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // wait until every item is taken and every result has come back
    task automatic drain();
        begin
            while (line_items.size() != 0 || predicted_reports.size() != 0)
                @(posedge clk);
            repeat (3) @(posedge clk);
        end
    endtask

    // start item plus returned levels of a scan path that is delay bits long
    task automatic queue_scan(input logic idle_level, input int unsigned delay,
                              input int unsigned count, input int unsigned flip_pct,
                              input bit noisy_lead);
        int unsigned len;
        logic        lvl;
        begin
            len = len_in_use();
            push_item(CMD_START, idle_level);
            for (int unsigned k = 0; k < count; k++)
            begin
                if (k < delay)
                    lvl = noisy_lead ? logic'($urandom_range(0, 1)) : idle_level;
                else
                    lvl = cfg_pattern[(k - delay) % len];
                if ($urandom_range(0, 99) < flip_pct)
                    lvl = ~lvl;
                push_item(CMD_SAMPLE, lvl);
            end
        end
    endtask

    // one random configuration followed by a few scans; phase 2 runs the long scan instead
    task automatic random_phase(input int unsigned phase_no);
        logic [CFG_W-1:0]   pat;
        logic [LEN_W-1:0]   len_val;
        logic [LIMIT_W-1:0] lim_val;
        int unsigned        used;
        int unsigned        delay;
        int unsigned        kind;
        begin
            case ($urandom_range(0, 5))
                0:       pat = '0;
                1:       pat = '1;
                default: pat = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 9))
                0:       len_val = 7'd0;
                1:       len_val = 7'd127;
                2:       len_val = 7'd64;
                3:       len_val = 7'd1;
                default: len_val = LEN_W'($urandom_range(2, 12));
            endcase
            used = (len_val == 0) ? 1 : (len_val > MAX_PATTERN_BITS ? MAX_PATTERN_BITS : len_val);
            case ($urandom_range(0, 9))
                0:       lim_val = 11'd0;
                1:       lim_val = 11'd1;
                2:       lim_val = 11'd1024;
                3:       lim_val = 11'd2047;
                default: lim_val = LIMIT_W'(used + $urandom_range(0, 30));
            endcase

            // long scan: full window, top limit, far return, no idling
            if (phase_no == 2)
            begin
                write_reg(REG_PATTERN_BITS, {$urandom, $urandom});
                write_reg(REG_PATTERN_LENGTH, 7'd127);
                write_reg(REG_ITERATION_LIMIT, 11'd2047);
                no_idle = 1'b1;
                delay = $urandom_range(520, 700);
                queue_scan($urandom_range(0, 1), delay, delay + MAX_PATTERN_BITS + 2, 0, 1'b1);
                drain();
                no_idle = 1'b0;
                return;
            end

            write_reg(REG_PATTERN_LENGTH, len_val);
            write_reg(REG_PATTERN_BITS, pat);
            write_reg(REG_ITERATION_LIMIT, lim_val);

            // carry on a scan left open by the last phase
            if ($urandom_range(0, 9) < 3)
            begin
                repeat ($urandom_range(1, 6))
                    push_item(CMD_SAMPLE, $urandom_range(0, 1));
            end

            repeat ($urandom_range(1, 3))
            begin
                delay = $urandom_range(0, 10);
                kind = $urandom_range(0, 9);
                case (kind)
                    0:       queue_scan($urandom_range(0, 1), 0, $urandom_range(1, 40), 50, 1'b0);
                    1:       queue_scan($urandom_range(0, 1), delay,
                                 $urandom_range(0, delay + used - 1), 0, 1'b0);
                    2:       queue_scan($urandom_range(0, 1), delay,
                                 delay + used + $urandom_range(0, 3), 10, 1'b0);
                    3:       queue_scan($urandom_range(0, 1), delay,
                                 delay + used + $urandom_range(0, 3), 0, 1'b1);
                    default: queue_scan($urandom_range(0, 1), delay,
                                 delay + used + $urandom_range(0, 3), 0, 1'b0);
                endcase
            end
            drain();
        end
    endtask

    initial
    begin
        int unsigned phase_no;
        int unsigned directed_items;
        phase_no = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // samples before any start
        push_item(CMD_SAMPLE, 1'b0);
        push_item(CMD_SAMPLE, 1'b1);
        drain();

        // zero length and zero limit clamp to one
        write_reg(REG_PATTERN_BITS, '1);
        write_reg(REG_PATTERN_LENGTH, 7'd0);
        write_reg(REG_ITERATION_LIMIT, 11'd0);
        push_item(CMD_START, 1'b1);
        push_item(CMD_SAMPLE, 1'b1);
        push_item(CMD_START, 1'b0);
        push_item(CMD_SAMPLE, 1'b0);
        push_item(CMD_SAMPLE, 1'b1);
        drain();

        // limit reached with toggles, then restart while running
        write_reg(REG_PATTERN_BITS, 64'h6);
        write_reg(REG_PATTERN_LENGTH, 7'd3);
        write_reg(REG_ITERATION_LIMIT, 11'd4);
        push_item(CMD_START, 1'b0);
        push_item(CMD_SAMPLE, 1'b1);
        push_item(CMD_SAMPLE, 1'b0);
        push_item(CMD_SAMPLE, 1'b1);
        push_item(CMD_SAMPLE, 1'b0);
        push_item(CMD_START, 1'b1);
        push_item(CMD_SAMPLE, 1'b1);
        push_item(CMD_START, 1'b0);
        push_item(CMD_SAMPLE, 1'b1);
        drain();

        directed_items = queued_items;
        while (queued_items < directed_items + RANDOM_ITEMS)
        begin
            random_phase(phase_no);
            phase_no++;
        end
        drain();
        repeat (5) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/spld_pkg.sv
hw/rtl/spld_window.sv
hw/rtl/serial_pattern_loopback_detector.sv
tb/tb_serial_pattern_loopback_detector.sv
